[src/prpbt_pkg.sv]
// Shared codes and control types for the polygon region point and box test.
package prpbt_pkg;

    // Operation codes carried by an input transaction.
    localparam logic [2:0] OP_WRITE  = 3'd0;
    localparam logic [2:0] OP_RECOMP = 3'd1;
    localparam logic [2:0] OP_FLIP   = 3'd2;
    localparam logic [2:0] OP_POINT  = 3'd3;
    localparam logic [2:0] OP_BOX    = 3'd4;

    // Per-edge step codes. Clip steps: bit 1 picks the axis, bit 0 the box side.
    localparam logic [2:0] STEP_CLIP_XMIN = 3'd0;
    localparam logic [2:0] STEP_CLIP_XMAX = 3'd1;
    localparam logic [2:0] STEP_CLIP_YMIN = 3'd2;
    localparam logic [2:0] STEP_CLIP_YMAX = 3'd3;
    localparam logic [2:0] STEP_FINAL     = 3'd4;
    localparam logic [2:0] STEP_CROSS     = 3'd5;

    // Action taken when a step's product compare resolves.
    localparam logic [2:0] ACT_NONE  = 3'd0;
    localparam logic [2:0] ACT_SET0  = 3'd1;
    localparam logic [2:0] ACT_LOW   = 3'd2;
    localparam logic [2:0] ACT_UP    = 3'd3;
    localparam logic [2:0] ACT_FIN   = 3'd4;
    localparam logic [2:0] ACT_CROSS = 3'd5;

    // Verdict codes.
    localparam logic [1:0] VERDICT_NONE   = 2'd0;
    localparam logic [1:0] VERDICT_HIT    = 2'd1;
    localparam logic [1:0] VERDICT_CORNER = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;
        logic       wr_vertex;
        logic       bb_clear;
        logic       pass_upd;
        logic       flip;
        logic       ld_p;
        logic       ld_c;
        logic       do_ops;
        logic       do_mul;
        logic       do_cmp;
        logic [2:0] step;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic lt;
        logic parity;
        logic box_miss;
        logic bound_empty;
    } t_status;

endpackage

[src/prpbt_ram.sv]
// Generic simple dual-port RAM with registered read data.
module prpbt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/prpbt_dpath.sv]
// Datapath: vertex memories, bounding box, query registers and exact product compare.
module prpbt_dpath import prpbt_pkg::*; #(
    parameter int MAX_VERTICES = 256,
    parameter int COORD_WIDTH  = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  t_cmd                            i_cmd,
    input  logic [$clog2(MAX_VERTICES)-1:0] i_addr,
    input  logic [7:0]                      i_vertex_slot,
    input  logic signed [31:0]              i_coord_x,
    input  logic signed [31:0]              i_coord_y,
    input  logic signed [31:0]              i_corner_x_max,
    input  logic signed [31:0]              i_corner_y_max,
    input  logic [15:0]                     i_image_height,
    output t_status                         o_status
);

    localparam int CW = COORD_WIDTH;
    localparam int DW = CW + 1;
    localparam int PW = 2 * DW;
    localparam int AW = $clog2(MAX_VERTICES);

    // Clamp a wide value to the signed coordinate range.
    function automatic logic [CW-1:0] sat64(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        logic signed [63:0] r;
        hi = (64'sd1 <<< (CW - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        r  = v;
        if (v > hi) begin
            r = hi;
        end else if (v < lo) begin
            r = lo;
        end
        return r[CW-1:0];
    endfunction

    // Sign-extend a coordinate by one bit for differences.
    function automatic logic signed [DW-1:0] ext(input logic [CW-1:0] v);
        return {v[CW-1], v};
    endfunction

    logic [CW-1:0] rd_x;
    logic [CW-1:0] rd_y;
    logic          slot_ok;
    logic [AW-1:0] waddr;
    logic          we_x;
    logic          we_y;
    logic [CW-1:0] wdata_x;
    logic [CW-1:0] wdata_y;
    logic [CW-1:0] flip_y;
    logic [CW-1:0] upd_y;

    logic signed [CW-1:0] r_qx, r_qy, r_mx, r_my;
    logic [15:0]          r_h;
    logic signed [CW-1:0] r_bmin_x, r_bmin_y, r_bmax_x, r_bmax_y;
    logic                 r_bempty;
    logic signed [CW-1:0] r_px, r_py, r_cx, r_cy;
    logic signed [DW-1:0] r_n0, r_d0, r_n1, r_d1;
    logic signed [DW-1:0] r_oa, r_ob, r_oc, r_od, r_cn, r_cd;
    logic [2:0]           r_act;
    logic signed [PW-1:0] r_pa, r_pb;
    logic                 r_parity;

    logic signed [DW-1:0] n_oa, n_ob, n_oc, n_od, n_cn, n_cd;
    logic [2:0]           n_act;
    logic signed [DW-1:0] pk, ck, bk, qxe, qye;
    logic                 lt;

    // Memory write steering: vertex writes from the input, y rewrites during a flip.
    assign slot_ok = (32'(i_vertex_slot) < MAX_VERTICES);
    assign waddr   = i_cmd.wr_vertex ? AW'(i_vertex_slot) : i_addr;
    assign we_x    = i_cmd.wr_vertex && slot_ok;
    assign we_y    = (i_cmd.wr_vertex && slot_ok) || (i_cmd.pass_upd && i_cmd.flip);
    assign wdata_x = sat64(64'(i_coord_x));
    assign wdata_y = i_cmd.wr_vertex ? sat64(64'(i_coord_y)) : flip_y;

    // Mirrored y: (height - 1) * 65536 - y, saturated, with the height held at accept.
    assign flip_y = sat64(((64'(r_h) - 64'sd1) <<< 16) - 64'(signed'(rd_y)));
    assign upd_y  = i_cmd.flip ? flip_y : rd_y;

    prpbt_ram #(.WIDTH(CW), .DEPTH(MAX_VERTICES)) u_ram_x (
        .i_clk   (i_clk),
        .i_we    (we_x),
        .i_waddr (waddr),
        .i_wdata (wdata_x),
        .i_raddr (i_addr),
        .o_rdata (rd_x)
    );

    prpbt_ram #(.WIDTH(CW), .DEPTH(MAX_VERTICES)) u_ram_y (
        .i_clk   (i_clk),
        .i_we    (we_y),
        .i_waddr (waddr),
        .i_wdata (wdata_y),
        .i_raddr (i_addr),
        .o_rdata (rd_y)
    );

    // Query registers, loaded when a transaction is accepted.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_qx <= sat64(64'(i_coord_x));
            r_qy <= sat64(64'(i_coord_y));
            r_mx <= sat64(64'(i_corner_x_max));
            r_my <= sat64(64'(i_corner_y_max));
            r_h  <= i_image_height;
        end
    end

    // Bounding box, rebuilt one vertex at a time.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bmin_x <= '0;
            r_bmin_y <= '0;
            r_bmax_x <= '0;
            r_bmax_y <= '0;
            r_bempty <= 1'b1;
        end else if (i_cmd.bb_clear) begin
            r_bmin_x <= '0;
            r_bmin_y <= '0;
            r_bmax_x <= '0;
            r_bmax_y <= '0;
            r_bempty <= 1'b1;
        end else if (i_cmd.pass_upd) begin
            r_bempty <= 1'b0;
            if (r_bempty) begin
                r_bmin_x <= rd_x;
                r_bmax_x <= rd_x;
                r_bmin_y <= upd_y;
                r_bmax_y <= upd_y;
            end else begin
                if ($signed(rd_x) < r_bmin_x) r_bmin_x <= rd_x;
                if ($signed(rd_x) > r_bmax_x) r_bmax_x <= rd_x;
                if ($signed(upd_y) < r_bmin_y) r_bmin_y <= upd_y;
                if ($signed(upd_y) > r_bmax_y) r_bmax_y <= upd_y;
            end
        end
    end

    // Operand selection for the current edge step.
    always_comb begin
        n_act = ACT_NONE;
        n_oa  = '0;
        n_ob  = '0;
        n_oc  = '0;
        n_od  = '0;
        n_cn  = '0;
        n_cd  = '0;
        qxe   = ext(r_qx);
        qye   = ext(r_qy);
        pk    = i_cmd.step[1] ? ext(r_py) : ext(r_px);
        ck    = i_cmd.step[1] ? ext(r_cy) : ext(r_cx);
        if (i_cmd.step[0]) begin
            bk = i_cmd.step[1] ? ext(r_my) : ext(r_mx);
        end else begin
            bk = i_cmd.step[1] ? qye : qxe;
        end
        case (i_cmd.step)
            STEP_CLIP_XMIN, STEP_CLIP_YMIN: begin
                if (pk < bk) begin
                    if (ck >= bk) begin
                        n_act = ACT_LOW;
                        n_cn  = bk - pk;
                        n_cd  = ck - pk;
                    end else begin
                        n_act = ACT_SET0;
                    end
                end else if (ck < bk) begin
                    n_act = ACT_UP;
                    n_cn  = pk - bk;
                    n_cd  = pk - ck;
                end
            end
            STEP_CLIP_XMAX, STEP_CLIP_YMAX: begin
                if (pk > bk) begin
                    if (ck <= bk) begin
                        n_act = ACT_LOW;
                        n_cn  = pk - bk;
                        n_cd  = pk - ck;
                    end else begin
                        n_act = ACT_SET0;
                    end
                end else if (ck > bk) begin
                    n_act = ACT_UP;
                    n_cn  = bk - pk;
                    n_cd  = ck - pk;
                end
            end
            STEP_FINAL: begin
                n_act = ACT_FIN;
                n_oa  = r_n0;
                n_ob  = r_d1;
                n_oc  = r_n1;
                n_od  = r_d0;
            end
            STEP_CROSS: begin
                if (r_py <= r_qy && r_cy > r_qy) begin
                    n_act = ACT_CROSS;
                    n_oa  = qxe - ext(r_px);
                    n_ob  = ext(r_cy) - ext(r_py);
                    n_oc  = qye - ext(r_py);
                    n_od  = ext(r_cx) - ext(r_px);
                end else if (r_py > r_qy && r_cy <= r_qy) begin
                    n_act = ACT_CROSS;
                    n_oa  = qxe - ext(r_cx);
                    n_ob  = ext(r_py) - ext(r_cy);
                    n_oc  = qye - ext(r_cy);
                    n_od  = ext(r_px) - ext(r_cx);
                end
            end
            default: begin
                n_act = ACT_NONE;
            end
        endcase
        // Fraction compares: lower bound n0/d0 < n/d, upper bound n/d < n1/d1.
        if (n_act == ACT_LOW) begin
            n_oa = r_n0;
            n_ob = n_cd;
            n_oc = n_cn;
            n_od = r_d0;
        end else if (n_act == ACT_UP) begin
            n_oa = n_cn;
            n_ob = r_d1;
            n_oc = r_n1;
            n_od = n_cd;
        end
    end

    assign lt = (r_pa < r_pb);

    // Edge registers, operands, products and the clip interval.
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_p) begin
            r_px <= rd_x;
            r_py <= rd_y;
        end
        if (i_cmd.ld_c) begin
            r_cx <= rd_x;
            r_cy <= rd_y;
            r_n0 <= '0;
            r_d0 <= DW'(1);
            r_n1 <= DW'(1);
            r_d1 <= DW'(1);
        end
        if (i_cmd.do_ops) begin
            r_act <= n_act;
            r_oa  <= n_oa;
            r_ob  <= n_ob;
            r_oc  <= n_oc;
            r_od  <= n_od;
            r_cn  <= n_cn;
            r_cd  <= n_cd;
        end
        if (i_cmd.do_mul) begin
            r_pa <= r_oa * r_ob;
            r_pb <= r_oc * r_od;
        end
        if (i_cmd.do_cmp) begin
            if (r_act == ACT_SET0) begin
                r_n0 <= DW'(1);
                r_d0 <= DW'(1);
            end else if (r_act == ACT_LOW && lt) begin
                r_n0 <= r_cn;
                r_d0 <= r_cd;
            end else if (r_act == ACT_UP && lt) begin
                r_n1 <= r_cn;
                r_d1 <= r_cd;
            end
            // After the crossing step the current vertex becomes the previous one.
            if (i_cmd.step == STEP_CROSS) begin
                r_px <= r_cx;
                r_py <= r_cy;
            end
        end
    end

    // Crossing parity.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parity <= 1'b0;
        end else if (i_cmd.ld_p) begin
            r_parity <= 1'b0;
        end else if (i_cmd.do_cmp && r_act == ACT_CROSS && lt) begin
            r_parity <= ~r_parity;
        end
    end

    assign o_status.lt          = lt;
    assign o_status.parity      = r_parity;
    assign o_status.bound_empty = r_bempty;
    assign o_status.box_miss    = (r_bmin_x > r_mx) || (r_qx > r_bmax_x) ||
                                  (r_bmin_y > r_my) || (r_qy > r_bmax_y);

endmodule

[src/prpbt_ctrl.sv]
// Controller: handshakes, vertex count register, pass and edge sequencing, result register.
module prpbt_ctrl import prpbt_pkg::*; #(
    parameter int MAX_VERTICES = 256
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [2:0]                      i_op,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [8:0]                      i_cfg_vertex_count,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_query_kind,
    output logic [1:0]                      o_verdict,
    output t_cmd                            o_cmd,
    output logic [$clog2(MAX_VERTICES)-1:0] o_addr,
    input  t_status                         i_status
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int NW = $clog2(MAX_VERTICES + 1);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_PASS_RD  = 4'd1;
    localparam logic [3:0] S_PASS_UPD = 4'd2;
    localparam logic [3:0] S_T_START  = 4'd3;
    localparam logic [3:0] S_T_LDP    = 4'd4;
    localparam logic [3:0] S_T_RD     = 4'd5;
    localparam logic [3:0] S_T_LDC    = 4'd6;
    localparam logic [3:0] S_T_OPS    = 4'd7;
    localparam logic [3:0] S_T_MUL    = 4'd8;
    localparam logic [3:0] S_T_CMP    = 4'd9;
    localparam logic [3:0] S_DONE     = 4'd10;

    logic [3:0]    r_state, n_state;
    logic [8:0]    r_vc;
    logic [NW-1:0] r_n, n_n, r_idx, n_idx, nm1;
    logic [2:0]    r_step, n_step;
    logic          r_box, n_box, r_flip, n_flip;
    logic [1:0]    r_res, n_res;
    logic          r_out_valid, r_out_kind;
    logic [1:0]    r_out_verdict;
    logic          accept;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign accept      = i_in_valid && o_in_ready;
    assign nm1         = r_n - NW'(1);
    assign n_n         = (32'(r_vc) > MAX_VERTICES) ? NW'(MAX_VERTICES) : NW'(r_vc);

    // Vertex count register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc <= '0;
        end else if (i_cfg_valid) begin
            r_vc <= i_cfg_vertex_count;
        end
    end

    // Next-state logic and datapath commands.
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_step  = r_step;
        n_box   = r_box;
        n_flip  = r_flip;
        n_res   = r_res;
        o_addr  = r_idx[AW-1:0];
        o_cmd   = '0;
        o_cmd.step = r_step;
        o_cmd.flip = r_flip;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load      = 1'b1;
                    o_cmd.wr_vertex = (i_op == OP_WRITE);
                    n_idx           = '0;
                    n_box           = (i_op == OP_BOX);
                    n_flip          = (i_op == OP_FLIP);
                    if (i_op inside {OP_RECOMP, OP_FLIP}) begin
                        o_cmd.bb_clear = 1'b1;
                        n_state        = S_PASS_RD;
                    end else if (i_op inside {OP_POINT, OP_BOX}) begin
                        n_state = S_T_START;
                    end
                end
            end
            S_PASS_RD: begin
                if (r_idx == r_n) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_PASS_UPD;
                end
            end
            S_PASS_UPD: begin
                o_cmd.pass_upd = 1'b1;
                n_idx          = r_idx + NW'(1);
                n_state        = S_PASS_RD;
            end
            S_T_START: begin
                o_addr = nm1[AW-1:0];
                if (r_n == '0 ||
                    (r_box && (i_status.bound_empty || i_status.box_miss))) begin
                    n_res   = VERDICT_NONE;
                    n_state = S_DONE;
                end else begin
                    n_state = S_T_LDP;
                end
            end
            S_T_LDP: begin
                o_cmd.ld_p = 1'b1;
                n_state    = S_T_RD;
            end
            S_T_RD: begin
                if (r_idx == r_n) begin
                    if (i_status.parity) begin
                        n_res = r_box ? VERDICT_CORNER : VERDICT_HIT;
                    end else begin
                        n_res = VERDICT_NONE;
                    end
                    n_state = S_DONE;
                end else begin
                    n_state = S_T_LDC;
                end
            end
            S_T_LDC: begin
                o_cmd.ld_c = 1'b1;
                n_step     = r_box ? STEP_CLIP_XMIN : STEP_CROSS;
                n_state    = S_T_OPS;
            end
            S_T_OPS: begin
                o_cmd.do_ops = 1'b1;
                n_state      = S_T_MUL;
            end
            S_T_MUL: begin
                o_cmd.do_mul = 1'b1;
                n_state      = S_T_CMP;
            end
            S_T_CMP: begin
                o_cmd.do_cmp = 1'b1;
                if (r_step == STEP_FINAL) begin
                    if (i_status.lt) begin
                        n_res   = VERDICT_HIT;
                        n_state = S_DONE;
                    end else begin
                        n_step  = STEP_CROSS;
                        n_state = S_T_OPS;
                    end
                end else if (r_step == STEP_CROSS) begin
                    n_idx   = r_idx + NW'(1);
                    n_state = S_T_RD;
                end else begin
                    n_step  = r_step + 3'd1;
                    n_state = S_T_OPS;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_step  <= STEP_CLIP_XMIN;
            r_box   <= 1'b0;
            r_flip  <= 1'b0;
            r_res   <= VERDICT_NONE;
            r_n     <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_step  <= n_step;
            r_box   <= n_box;
            r_flip  <= n_flip;
            r_res   <= n_res;
            if (accept) begin
                r_n <= n_n;
            end
        end
    end

    // Output register; a waiting result does not block new input transactions.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && (!r_out_valid || i_out_ready)) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!r_out_valid || i_out_ready)) begin
            r_out_kind    <= r_box;
            r_out_verdict <= r_res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_query_kind = r_out_kind;
    assign o_verdict    = r_out_verdict;

endmodule

[src/polygon_region_point_box_test.sv]
// Top level of the polygon region point and box test.
//
// Input channel (i_in_valid / o_in_ready) takes one transaction per item: write a
// vertex, rebuild the bounding box, mirror y for an image height, test a point,
// or test a box. The configuration channel (i_cfg_valid / o_cfg_ready) writes
// the vertex count and is always ready. Point and box tests each return one
// transaction on the output channel (o_out_valid / i_out_ready).
// A bounding-box rebuild or y flip reads each of the N vertices in use once; a
// point or box test walks the edges of those N vertices in turn. Each edge runs
// through one shared pair of signed multipliers, each compare going through
// operand select, multiply and compare, and the vertex memories give one vertex
// per read cycle. Only one item is worked on at a time.
// The finished result sits in an output register; a new input transaction is
// accepted while it waits, and the next result holds until the receiver takes
// the previous one. Reset clears the vertex count and the bounding box; vertex
// memory contents are undefined until written.
module polygon_region_point_box_test import prpbt_pkg::*; #(
    parameter int MAX_VERTICES = 256,
    parameter int COORD_WIDTH  = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_op,
    input  logic [7:0]         i_vertex_slot,
    input  logic signed [31:0] i_coord_x,
    input  logic signed [31:0] i_coord_y,
    input  logic signed [31:0] i_corner_x_max,
    input  logic signed [31:0] i_corner_y_max,
    input  logic [15:0]        i_image_height,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [8:0]         i_cfg_vertex_count,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_query_kind,
    output logic [1:0]         o_verdict
);

    t_cmd                            cmd;
    t_status                         status;
    logic [$clog2(MAX_VERTICES)-1:0] addr;

    prpbt_ctrl #(.MAX_VERTICES(MAX_VERTICES)) u_ctrl (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_op               (i_op),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_vertex_count (i_cfg_vertex_count),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_query_kind       (o_query_kind),
        .o_verdict          (o_verdict),
        .o_cmd              (cmd),
        .o_addr             (addr),
        .i_status           (status)
    );

    prpbt_dpath #(.MAX_VERTICES(MAX_VERTICES), .COORD_WIDTH(COORD_WIDTH)) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_addr         (addr),
        .i_vertex_slot  (i_vertex_slot),
        .i_coord_x      (i_coord_x),
        .i_coord_y      (i_coord_y),
        .i_corner_x_max (i_corner_x_max),
        .i_corner_y_max (i_corner_y_max),
        .i_image_height (i_image_height),
        .o_status       (status)
    );

endmodule

[verif/polygon_region_point_box_test_test.sv]
// Testbench for the polygon region point and box test, checked against its own predictor.
`timescale 1ns / 100ps

module polygon_region_point_box_test_test;
    import prpbt_pkg::*;

    localparam int  NSLOTS   = 256;
    localparam int  DRAIN    = 600;
    localparam int  UNIT     = 65536;
    localparam bit  QK_POINT = 1'b0;
    localparam bit  QK_BOX   = 1'b1;
    localparam logic [2:0] OP_NOP5 = 3'd5;
    localparam logic [2:0] OP_NOP6 = 3'd6;
    localparam logic [2:0] OP_NOP7 = 3'd7;
    localparam logic signed [31:0] CMAX = 32'sh7fffffff;
    localparam logic signed [31:0] CMIN = 32'sh80000000;

    // One input transaction, or a vertex count write when is_cfg is set.
    typedef struct {
        bit                 is_cfg;
        logic [2:0]         op;
        logic [7:0]         slot;
        logic signed [31:0] x, y, xm, ym;
        logic [15:0]        h;
        bit                 fixed;
        logic [1:0]         verdict;
    } t_poly_item;

    typedef struct {
        logic       kind;
        logic [1:0] verdict;
    } t_answer;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [2:0]         i_op;
    logic [7:0]         i_vertex_slot;
    logic signed [31:0] i_coord_x, i_coord_y, i_corner_x_max, i_corner_y_max;
    logic [15:0]        i_image_height;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [8:0]         i_cfg_vertex_count;
    logic               o_out_valid;
    logic               i_out_ready;
    logic               o_query_kind;
    logic [1:0]         o_verdict;

    polygon_region_point_box_test i_dut (.*);

    // Predictor state.
    longint      poly_x[NSLOTS];
    longint      poly_y[NSLOTS];
    bit          slot_written[NSLOTS];
    longint      box_lo_x, box_lo_y, box_hi_x, box_hi_y;
    bit          box_empty;
    int unsigned poly_count;
    t_answer     pending_answers[$];

    int mismatches;
    int failures;
    int in_idle;
    int out_idle;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Run limit.
    initial begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic longint clamp_coord(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic int unsigned active_vertices();
        return (poly_count > NSLOTS) ? NSLOTS : poly_count;
    endfunction

    // Exact compare a*b < c*d.
    function automatic bit product_lt(longint a, longint b, longint c, longint d);
        logic signed [127:0] wa, wb, wc, wd;
        wa = a;
        wb = b;
        wc = c;
        wd = d;
        return (wa * wb) < (wc * wd);
    endfunction

    function automatic void rebuild_box();
        box_empty = 1'b1;
        box_lo_x = 0;
        box_lo_y = 0;
        box_hi_x = 0;
        box_hi_y = 0;
        for (int i = 0; i < active_vertices(); i++) begin
            if (box_empty) begin
                box_lo_x = poly_x[i];
                box_hi_x = poly_x[i];
                box_lo_y = poly_y[i];
                box_hi_y = poly_y[i];
                box_empty = 1'b0;
            end else begin
                if (poly_x[i] < box_lo_x) box_lo_x = poly_x[i];
                if (poly_x[i] > box_hi_x) box_hi_x = poly_x[i];
                if (poly_y[i] < box_lo_y) box_lo_y = poly_y[i];
                if (poly_y[i] > box_hi_y) box_hi_y = poly_y[i];
            end
        end
    endfunction

    // Does edge p->c cross the rightward ray from q.
    function automatic bit ray_crosses(longint px, longint py, longint cx, longint cy,
                                       longint qx, longint qy);
        if (py <= qy && cy > qy) return product_lt(qx - px, cy - py, qy - py, cx - px);
        if (py > qy && cy <= qy) return product_lt(qx - cx, py - cy, qy - cy, px - cx);
        return 1'b0;
    endfunction

    function automatic logic [1:0] point_verdict(longint qx, longint qy);
        int unsigned n;
        int unsigned j;
        bit          odd;
        n = active_vertices();
        odd = 1'b0;
        if (n == 0) return VERDICT_NONE;
        for (int unsigned i = 0; i < n; i++) begin
            j = (i == 0) ? n - 1 : i - 1;
            odd ^= ray_crosses(poly_x[j], poly_y[j], poly_x[i], poly_y[i], qx, qy);
        end
        return odd ? VERDICT_HIT : VERDICT_NONE;
    endfunction

    // Parametric clip of edge p->c against the box, lambdas kept as fractions.
    function automatic bit edge_touches(longint p[2], longint c[2], longint lo[2],
                                        longint hi[2]);
        longint n0, d0, n1, d1, n, d;
        n0 = 0; d0 = 1; n1 = 1; d1 = 1;
        for (int k = 0; k < 2; k++) begin
            if (p[k] < lo[k]) begin
                if (c[k] >= lo[k]) begin
                    n = lo[k] - p[k]; d = c[k] - p[k];
                    if (product_lt(n0, d, n, d0)) begin n0 = n; d0 = d; end
                end else begin
                    n0 = 1; d0 = 1;
                end
            end else if (c[k] < lo[k]) begin
                n = p[k] - lo[k]; d = p[k] - c[k];
                if (product_lt(n, d1, n1, d)) begin n1 = n; d1 = d; end
            end
            if (p[k] > hi[k]) begin
                if (c[k] <= hi[k]) begin
                    n = p[k] - hi[k]; d = p[k] - c[k];
                    if (product_lt(n0, d, n, d0)) begin n0 = n; d0 = d; end
                end else begin
                    n0 = 1; d0 = 1;
                end
            end else if (c[k] > hi[k]) begin
                n = hi[k] - p[k]; d = c[k] - p[k];
                if (product_lt(n, d1, n1, d)) begin n1 = n; d1 = d; end
            end
        end
        return product_lt(n0, d1, n1, d0);
    endfunction

    function automatic logic [1:0] box_verdict(longint lo[2], longint hi[2]);
        int unsigned n;
        int unsigned j;
        bit          odd;
        longint      p[2], c[2];
        n = active_vertices();
        odd = 1'b0;
        if (n == 0 || box_empty) return VERDICT_NONE;
        if (box_lo_x > hi[0] || lo[0] > box_hi_x || box_lo_y > hi[1] || lo[1] > box_hi_y)
            return VERDICT_NONE;
        for (int unsigned i = 0; i < n; i++) begin
            j = (i == 0) ? n - 1 : i - 1;
            p[0] = poly_x[j]; p[1] = poly_y[j];
            c[0] = poly_x[i]; c[1] = poly_y[i];
            if (edge_touches(p, c, lo, hi)) return VERDICT_HIT;
            odd ^= ray_crosses(p[0], p[1], c[0], c[1], lo[0], lo[1]);
        end
        return odd ? VERDICT_CORNER : VERDICT_NONE;
    endfunction

    // Apply one accepted transaction to the predictor and queue its answer.
    function automatic void apply_item(t_poly_item t);
        longint  lo[2], hi[2];
        t_answer a;
        case (t.op)
            OP_WRITE: begin
                poly_x[t.slot] = clamp_coord(t.x);
                poly_y[t.slot] = clamp_coord(t.y);
                slot_written[t.slot] = 1'b1;
            end
            OP_RECOMP: rebuild_box();
            OP_FLIP: begin
                for (int i = 0; i < active_vertices(); i++)
                    poly_y[i] = clamp_coord((longint'(t.h) - 1) * UNIT - poly_y[i]);
                rebuild_box();
            end
            OP_POINT: begin
                a.kind = QK_POINT;
                a.verdict = t.fixed ? t.verdict : point_verdict(t.x, t.y);
                pending_answers.push_back(a);
            end
            OP_BOX: begin
                lo[0] = t.x; lo[1] = t.y;
                hi[0] = t.xm; hi[1] = t.ym;
                a.kind = QK_BOX;
                a.verdict = t.fixed ? t.verdict : box_verdict(lo, hi);
                pending_answers.push_back(a);
            end
            default: ;
        endcase
    endfunction

    // Send one transaction, idling first at the current sender rate.
    task automatic send_item(t_poly_item t);
        while ($urandom_range(0, 99) < in_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_op           <= t.op;
        i_vertex_slot  <= t.slot;
        i_coord_x      <= t.x;
        i_coord_y      <= t.y;
        i_corner_x_max <= t.xm;
        i_corner_y_max <= t.ym;
        i_image_height <= t.h;
        do @(posedge i_clk); while (!o_in_ready);
        apply_item(t);
    endtask

    // Wait until every answer is back and the block has had time to finish.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic write_count(int unsigned c);
        settle();
        i_cfg_valid        <= 1'b1;
        i_cfg_vertex_count <= c[8:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        poly_count = c;
    endtask

    function automatic t_poly_item make_op(logic [2:0] op, logic signed [31:0] x,
                                           logic signed [31:0] y, logic signed [31:0] xm,
                                           logic signed [31:0] ym);
        t_poly_item t;
        t.is_cfg = 1'b0;
        t.op = op;
        t.slot = $urandom_range(0, 255);
        t.x = x; t.y = y; t.xm = xm; t.ym = ym;
        t.h = $urandom_range(0, 65535);
        t.fixed = 1'b0;
        t.verdict = VERDICT_NONE;
        return t;
    endfunction

    function automatic logic signed [31:0] rand_coord(int span);
        if ($urandom_range(0, 15) == 0) return $urandom;
        return clamp_coord(longint'($urandom_range(0, 2 * span)) - span);
    endfunction

    // Random transaction around a polygon of the given spread.
    function automatic t_poly_item random_item(int span);
        t_poly_item  t;
        int unsigned sel;
        longint      ax, ay, bx, by;
        sel = $urandom_range(0, 99);
        ax = rand_coord(span);
        ay = rand_coord(span);
        bx = clamp_coord(ax + $urandom_range(0, span));
        by = clamp_coord(ay + $urandom_range(0, span));
        if ($urandom_range(0, 9) == 0) begin
            bx = rand_coord(span);
            by = rand_coord(span);
        end
        if (sel < 25) t = make_op(OP_WRITE, ax, ay, $urandom, $urandom);
        else if (sel < 33) t = make_op(OP_RECOMP, ax, ay, bx, by);
        else if (sel < 40) t = make_op(OP_FLIP, ax, ay, bx, by);
        else if (sel < 67) t = make_op(OP_POINT, ax, ay, bx, by);
        else if (sel < 96) t = make_op(OP_BOX, ax, ay, bx, by);
        else t = make_op(3'($urandom_range(5, 7)), ax, ay, bx, by);
        if (t.op == OP_WRITE && active_vertices() != 0 && $urandom_range(0, 3) != 0)
            t.slot = $urandom_range(0, active_vertices() - 1);
        // Mostly small heights keep the flipped polygon near the test region.
        if (t.op == OP_FLIP && $urandom_range(0, 3) != 0)
            t.h = $urandom_range(0, 40);
        return t;
    endfunction

    // Receiver stalls.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= out_idle);
    end

    // Answer checker.
    always @(posedge i_clk) begin
        t_answer exp_a;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_answers.size() == 0) begin
                failures++;
                if (mismatches < 10)
                    $display("Unexpected answer kind=%0d verdict=%0d", o_query_kind, o_verdict);
                mismatches++;
            end else begin
                exp_a = pending_answers.pop_front();
                if (o_query_kind !== exp_a.kind || o_verdict !== exp_a.verdict) begin
                    failures++;
                    if (mismatches < 10)
                        $display("Answer mismatch: expected kind=%0d verdict=%0d, got kind=%0d verdict=%0d",
                                 exp_a.kind, exp_a.verdict, o_query_kind, o_verdict);
                    mismatches++;
                end
            end
        end
    end

    // Stimulus.
    initial begin
        t_poly_item  rows[$];
        t_poly_item  t;
        int unsigned counts[12] = '{3, 4, 7, 16, 0, 256, 5, 511, 3, 9, 6, 12};
        int unsigned lengths[12] = '{200, 180, 170, 140, 40, 25, 180, 25, 200, 170, 170, 175};
        int          spans[12] = '{20 * UNIT, 200, 20 * UNIT, 1 << 24, 20 * UNIT, 20 * UNIT,
                                   300 * UNIT, 20 * UNIT, 8, 20 * UNIT, 1 << 30, 20 * UNIT};
        int          fill_span;

        mismatches = 0;
        failures   = 0;
        in_idle    = 0;
        out_idle   = 0;
        poly_count = 0;
        box_empty  = 1'b1;
        box_lo_x = 0; box_lo_y = 0; box_hi_x = 0; box_hi_y = 0;
        foreach (slot_written[i]) slot_written[i] = 1'b0;
        i_rst_n            <= 1'b0;
        i_in_valid         <= 1'b0;
        i_op               <= OP_WRITE;
        i_vertex_slot      <= '0;
        i_coord_x          <= '0;
        i_coord_y          <= '0;
        i_corner_x_max     <= '0;
        i_corner_y_max     <= '0;
        i_image_height     <= '0;
        i_cfg_valid        <= 1'b0;
        i_cfg_vertex_count <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows: empty polygon, a 10x10 square, ignored ops, extremes, flips.
        t = make_op(OP_POINT, 0, 0, 0, 0); t.fixed = 1; rows.push_back(t);
        t = make_op(OP_BOX, CMIN, CMIN, CMAX, CMAX); t.fixed = 1; rows.push_back(t);
        t = make_op(OP_WRITE, 0, 0, 0, 0); t.slot = 0; rows.push_back(t);
        t = make_op(OP_WRITE, 10 * UNIT, 0, 0, 0); t.slot = 1; rows.push_back(t);
        t = make_op(OP_WRITE, 10 * UNIT, 10 * UNIT, 0, 0); t.slot = 2; rows.push_back(t);
        t = make_op(OP_WRITE, 0, 10 * UNIT, 0, 0); t.slot = 3; rows.push_back(t);
        t = make_op(OP_WRITE, CMAX, CMIN, 0, 0); t.slot = 8'hff; rows.push_back(t);
        rows.push_back(make_op(OP_NOP5, CMAX, CMAX, CMAX, CMAX));
        rows.push_back(make_op(OP_NOP6, CMIN, CMIN, CMIN, CMIN));
        rows.push_back(make_op(OP_NOP7, 0, 0, 0, 0));
        t = make_op(OP_WRITE, 0, 0, 0, 0); t.is_cfg = 1; t.h = 4; rows.push_back(t);
        // Stale bounding box is still empty, so the box misses.
        t = make_op(OP_BOX, 0, 0, 10 * UNIT, 10 * UNIT); t.fixed = 1; rows.push_back(t);
        rows.push_back(make_op(OP_RECOMP, 0, 0, 0, 0));
        rows.push_back(make_op(OP_POINT, 5 * UNIT, 5 * UNIT, 0, 0));
        rows.push_back(make_op(OP_POINT, CMAX, CMAX, 0, 0));
        rows.push_back(make_op(OP_POINT, CMIN, CMIN, 0, 0));
        rows.push_back(make_op(OP_BOX, 4 * UNIT, 4 * UNIT, 6 * UNIT, 6 * UNIT));
        rows.push_back(make_op(OP_BOX, -UNIT, -UNIT, 20 * UNIT, 20 * UNIT));
        rows.push_back(make_op(OP_BOX, 20 * UNIT, 20 * UNIT, 30 * UNIT, 30 * UNIT));
        rows.push_back(make_op(OP_BOX, 6 * UNIT, 6 * UNIT, 4 * UNIT, 4 * UNIT));
        t = make_op(OP_FLIP, 0, 0, 0, 0); t.h = 16'h0000; rows.push_back(t);
        rows.push_back(make_op(OP_POINT, 5 * UNIT, -6 * UNIT, 0, 0));
        t = make_op(OP_FLIP, 0, 0, 0, 0); t.h = 16'hffff; rows.push_back(t);
        rows.push_back(make_op(OP_BOX, CMIN, CMIN, CMAX, CMAX));
        foreach (rows[i]) begin
            if (rows[i].is_cfg) write_count(rows[i].h);
            else send_item(rows[i]);
        end

        // Random phases over several vertex counts and idling mixes.
        for (int ph = 0; ph < 12; ph++) begin
            in_idle  = (ph < 4) ? 32 : (ph < 8) ? 56 : 0;
            out_idle = (ph < 4) ? 56 : (ph < 8) ? 32 : 0;
            fill_span = (spans[ph] > 20 * UNIT) ? 20 * UNIT : spans[ph];
            // Every vertex in use must be written before the count covers it.
            for (int s = 0; s < NSLOTS && s < counts[ph]; s++) begin
                if (!slot_written[s]) begin
                    t = make_op(OP_WRITE, rand_coord(fill_span), rand_coord(fill_span), 0, 0);
                    t.slot = s;
                    send_item(t);
                end
            end
            write_count(counts[ph]);
            for (int k = 0; k < lengths[ph]; k++)
                send_item(random_item(spans[ph]));
        end

        settle();
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
